### src/ahd2_pkg.sv
`default_nettype none

package ahd2_pkg;

  // Field and state widths.
  localparam int unsigned SampleW = 16;
  localparam int unsigned TapW    = 32;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned InShift = 10;
  localparam int unsigned OutShift = 11;
  localparam int unsigned ProdW   = TapW + CoefW + 1;
  localparam int unsigned SecW    = 2;

  // Rounding offset added before the output shift.
  localparam logic [TapW-1:0] RoundOfs = 32'd1024;

  // Saturation bounds of the output sample.
  localparam logic signed [SampleW-1:0] SatMax = 16'sd32767;
  localparam logic signed [SampleW-1:0] SatMin = -16'sd32768;

  // Section indexes of a three-section chain.
  localparam logic [SecW-1:0] Sec0 = 2'd0;
  localparam logic [SecW-1:0] Sec1 = 2'd1;
  localparam logic [SecW-1:0] Sec2 = 2'd2;

  // Q16 coefficients, lower chain (first sample) and upper chain (second sample).
  function automatic logic [CoefW-1:0] lo_coef(input logic [SecW-1:0] sec);
    logic [CoefW-1:0] c;
    case (sec)
      Sec0:    c = 16'd12199;
      Sec1:    c = 16'd37471;
      default: c = 16'd60255;
    endcase
    return c;
  endfunction

  function automatic logic [CoefW-1:0] hi_coef(input logic [SecW-1:0] sec);
    logic [CoefW-1:0] c;
    case (sec)
      Sec0:    c = 16'd3284;
      Sec1:    c = 16'd24441;
      default: c = 16'd49528;
    endcase
    return c;
  endfunction

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEC0,
    ST_SEC1,
    ST_SEC2,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;
    logic            sec_en;
    logic [SecW-1:0] sec;
    logic            out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_blocked;
  } status_t;

endpackage

`default_nettype wire

### src/allpass_halfband_decimator_by2_core.sv
`default_nettype none

// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  sample_first, sample_second, end_of_block
// out_     output     out_valid/out_stall sample_out, last_out
//
// An item is accepted in a load cycle, then passes through the three allpass
// section steps (both chains side by side, one multiplier per chain) and an
// output step that registers the rounded, saturated sum.
// A new item is taken only in the idle state, after the previous result is registered.
// Reset (rst_n low, synchronous) clears the filter state and the controller.
// A stalled output holds the next item in its last cycle until room frees up.

module allpass_halfband_decimator_by2_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [ahd2_pkg::SampleW-1:0] in_sample_first,
  input  wire logic signed [ahd2_pkg::SampleW-1:0] in_sample_second,
  input  wire logic                                in_end_of_block,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [ahd2_pkg::SampleW-1:0]      out_sample_out,
  output logic                                     out_last_out
);

  ahd2_pkg::cmd_t    cmd;
  ahd2_pkg::status_t status;

  // Sequencer for load, section steps and output.
  ahd2_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Filter state, section arithmetic and output register.
  ahd2_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_sample_first  (in_sample_first),
    .in_sample_second (in_sample_second),
    .in_end_of_block  (in_end_of_block),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_sample_out   (out_sample_out),
    .out_last_out     (out_last_out),
    .cmd              (cmd),
    .status           (status)
  );

endmodule

`default_nettype wire

### src/ahd2_ctrl.sv
`default_nettype none

module ahd2_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ahd2_pkg::status_t status,
  output ahd2_pkg::cmd_t         cmd
);

  ahd2_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ahd2_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: three section steps, then one output step that waits for room.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ahd2_pkg::ST_IDLE: if (in_valid) state_nxt = ahd2_pkg::ST_SEC0;
      ahd2_pkg::ST_SEC0: state_nxt = ahd2_pkg::ST_SEC1;
      ahd2_pkg::ST_SEC1: state_nxt = ahd2_pkg::ST_SEC2;
      ahd2_pkg::ST_SEC2: state_nxt = ahd2_pkg::ST_OUT;
      ahd2_pkg::ST_OUT:  if (!status.out_blocked) state_nxt = ahd2_pkg::ST_IDLE;
      default:           state_nxt = ahd2_pkg::ST_IDLE;
    endcase
  end

  // Outputs: commands for the datapath and the input stall.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ahd2_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ahd2_pkg::ST_SEC0: begin
        cmd.sec_en = 1'b1;
        cmd.sec    = ahd2_pkg::Sec0;
      end
      ahd2_pkg::ST_SEC1: begin
        cmd.sec_en = 1'b1;
        cmd.sec    = ahd2_pkg::Sec1;
      end
      ahd2_pkg::ST_SEC2: begin
        cmd.sec_en = 1'b1;
        cmd.sec    = ahd2_pkg::Sec2;
      end
      ahd2_pkg::ST_OUT: begin
        cmd.out_load = !status.out_blocked;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/ahd2_datapath.sv
`default_nettype none

module ahd2_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic signed [ahd2_pkg::SampleW-1:0] in_sample_first,
  input  wire logic signed [ahd2_pkg::SampleW-1:0] in_sample_second,
  input  wire logic                                in_end_of_block,
  input  wire logic                                out_stall,
  output logic                                     out_valid,
  output logic signed [ahd2_pkg::SampleW-1:0]      out_sample_out,
  output logic                                     out_last_out,
  input  wire ahd2_pkg::cmd_t                      cmd,
  output ahd2_pkg::status_t                        status
);

  localparam int unsigned TapW = ahd2_pkg::TapW;
  localparam int unsigned ProdW = ahd2_pkg::ProdW;
  localparam int unsigned CoefW = ahd2_pkg::CoefW;
  localparam int unsigned SampleW = ahd2_pkg::SampleW;

  // Filter state: four words per chain.
  logic [TapW-1:0] lo_tap_r [4];
  logic [TapW-1:0] hi_tap_r [4];
  // Value entering the current section of each chain.
  logic [TapW-1:0] lo_cur_r, hi_cur_r;
  logic            last_r;

  logic                      out_valid_r;
  logic signed [SampleW-1:0] out_sample_r;
  logic                      out_last_r;

  logic [TapW-1:0] lo_old, lo_prev, hi_old, hi_prev;
  logic [TapW-1:0] lo_res, hi_res;
  logic [TapW-1:0] lo_diff, hi_diff;
  logic signed [ProdW-1:0] lo_prod, hi_prod;
  logic [TapW-1:0] sum;
  logic signed [SampleW-1:0] sat;

  // Sign-extend a sample and scale it by 2^10.
  function automatic logic [TapW-1:0] scale_in(input logic signed [SampleW-1:0] s);
    logic [TapW-1:0] w;
    w = TapW'(signed'(s));
    return w << ahd2_pkg::InShift;
  endfunction

  // Section operands: the old output and the previous input of the section.
  always_comb begin
    case (cmd.sec)
      ahd2_pkg::Sec0: begin
        lo_old = lo_tap_r[1]; lo_prev = lo_tap_r[0];
        hi_old = hi_tap_r[1]; hi_prev = hi_tap_r[0];
      end
      ahd2_pkg::Sec1: begin
        lo_old = lo_tap_r[2]; lo_prev = lo_tap_r[1];
        hi_old = hi_tap_r[2]; hi_prev = hi_tap_r[1];
      end
      default: begin
        lo_old = lo_tap_r[3]; lo_prev = lo_tap_r[2];
        hi_old = hi_tap_r[3]; hi_prev = hi_tap_r[2];
      end
    endcase
  end

  // One allpass section per chain: prev + floor(coef * (x - old) / 2^16).
  always_comb begin
    lo_diff = lo_cur_r - lo_old;
    hi_diff = hi_cur_r - hi_old;
    lo_prod = signed'({1'b0, ahd2_pkg::lo_coef(cmd.sec)}) * signed'(lo_diff);
    hi_prod = signed'({1'b0, ahd2_pkg::hi_coef(cmd.sec)}) * signed'(hi_diff);
    lo_res  = lo_prev + lo_prod[CoefW +: TapW];
    hi_res  = hi_prev + hi_prod[CoefW +: TapW];
  end

  // Sum of the chain outputs, rounded, shifted and saturated.
  always_comb begin
    sum = lo_tap_r[3] + hi_tap_r[3] + ahd2_pkg::RoundOfs;
    if (sum[TapW-1:ahd2_pkg::OutShift+SampleW-1] == '0 ||
        sum[TapW-1:ahd2_pkg::OutShift+SampleW-1] == '1) begin
      sat = signed'(sum[ahd2_pkg::OutShift +: SampleW]);
    end else if (sum[TapW-1]) begin
      sat = ahd2_pkg::SatMin;
    end else begin
      sat = ahd2_pkg::SatMax;
    end
  end

  // Filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        lo_tap_r[i] <= '0;
        hi_tap_r[i] <= '0;
      end
    end else if (cmd.sec_en) begin
      case (cmd.sec)
        ahd2_pkg::Sec0: begin
          lo_tap_r[0] <= lo_cur_r;
          hi_tap_r[0] <= hi_cur_r;
        end
        ahd2_pkg::Sec1: begin
          lo_tap_r[1] <= lo_cur_r;
          hi_tap_r[1] <= hi_cur_r;
        end
        default: begin
          lo_tap_r[2] <= lo_cur_r;
          hi_tap_r[2] <= hi_cur_r;
          lo_tap_r[3] <= lo_res;
          hi_tap_r[3] <= hi_res;
        end
      endcase
    end
  end

  // Current section inputs: the scaled samples, then each section's result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_cur_r <= scale_in(in_sample_first);
      hi_cur_r <= scale_in(in_sample_second);
      last_r   <= in_end_of_block;
    end else if (cmd.sec_en) begin
      lo_cur_r <= lo_res;
      hi_cur_r <= hi_res;
    end
  end

  // Output register and its valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sample_r <= sat;
      out_last_r   <= last_r;
    end
  end

  assign status.out_blocked = out_valid_r && out_stall;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_last_out   = out_last_r;

endmodule

`default_nettype wire
